### hw/rtl/dds_sine_generator_assert.svh
// Assertion macros used by the sine generator sequencer RTL.
`ifndef DDS_SINE_GENERATOR_ASSERT_SVH
`define DDS_SINE_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DSG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define DSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dsg_pkg.sv
// Types, constants and the sine table generator for the DDS sine source.
package dsg_pkg;

  // Channel widths
  localparam int DAC_W       = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int STEP_W      = 32;
  localparam int LEVEL_W     = 12;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_OFFSET     = 2'd1,
    REG_AMPLITUDE  = 2'd2
  } dsg_reg_t;

  localparam logic [LEVEL_W-1:0] OFFSET_RESET    = 12'd1250;
  localparam logic [LEVEL_W-1:0] AMPLITUDE_RESET = 12'd1000;

  // Scaling datapath widths
  localparam int SINE_W   = 16;   // signed table entry, +/-32767
  localparam int NUM_W    = 30;   // offset*2^15 + sine*amplitude, signed
  localparam int MAG_W    = 28;   // positive part of the numerator
  localparam int RECIP_W  = 18;
  localparam int PROD_W   = MAG_W + RECIP_W;
  localparam int Q_W      = 14;   // quotient before clamping
  localparam int WIDE_W   = 41;   // numerator times 4095, remainder check

  // code = floor(num * 4095 / (2500 * 2^15))
  localparam logic [WIDE_W-1:0]  FULL_SCALE  = 41'd81920000;
  // floor(4095 * 2^32 / FULL_SCALE); estimate is exact or one low
  localparam logic [RECIP_W-1:0] RECIP_K     = 18'd214695;
  localparam logic [DAC_W-1:0]   CODE_MAX    = 12'd4095;

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  // Datapath commands issued by the controller
  typedef struct packed {
    logic acc_step;
    logic rom_load;
    logic mac_load;
    logic mulk_load;
    logic qest_load;
    logic out_load;
    logic last;
  } dsg_cmd_t;

  // (a*b) >> 62 over the full product
  function automatic logic [63:0] mul_sh62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Taylor term divisor (2n)(2n+1)
  function automatic logic [63:0] div_taylor(input logic [63:0] t, input int n);
    logic [63:0] q;
    unique case (n)
      1:       q = t / 64'd6;
      2:       q = t / 64'd20;
      3:       q = t / 64'd42;
      4:       q = t / 64'd72;
      5:       q = t / 64'd110;
      6:       q = t / 64'd156;
      7:       q = t / 64'd210;
      8:       q = t / 64'd272;
      9:       q = t / 64'd342;
      10:      q = t / 64'd420;
      11:      q = t / 64'd506;
      12:      q = t / 64'd600;
      13:      q = t / 64'd702;
      14:      q = t / 64'd812;
      15:      q = t / 64'd930;
      16:      q = t / 64'd1056;
      17:      q = t / 64'd1190;
      18:      q = t / 64'd1332;
      19:      q = t / 64'd1482;
      20:      q = t / 64'd1640;
      21:      q = t / 64'd1806;
      22:      q = t / 64'd1980;
      23:      q = t / 64'd2162;
      default: q = 64'd0;
    endcase
    return q;
  endfunction

  // Table entry k: round(32767*sin(2*pi*k/2^tib)), fixed point Q62 series
  function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] k, input int tib);
    logic [63:0] rom_size;
    logic [63:0] half;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic        neg;
    rom_size = 64'd1 << tib;
    half     = rom_size >> 1;
    neg      = (k & (rom_size - 64'd1)) >= half;
    m        = k & (half - 64'd1);
    if (m > (half >> 1)) begin
      m = half - m;
    end
    x = (PI_Q62 >> (tib - 1)) * m + (((PI_Q62 & (half - 64'd1)) * m) >> (tib - 1));
    x2   = mul_sh62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 24; n++) begin
      if (term != 64'd0) begin
        term = div_taylor(mul_sh62(term, x2), n);
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    r = (mul_sh62(sum, 64'd65534) + 64'd1) >> 1;
    return neg ? (~r[SINE_W-1:0] + 16'd1) : r[SINE_W-1:0];
  endfunction

endpackage

### hw/rtl/dsg_refill_if.sv
// Refill request channel.
interface dsg_refill_if;
  logic valid;
  logic ready;
  logic refill_request;

  modport source (output valid, output refill_request, input ready);
  modport sink (input valid, input refill_request, output ready);
endinterface

### hw/rtl/dsg_sample_if.sv
// Converter sample channel.
interface dsg_sample_if import dsg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DAC_W-1:0] dac_code;
  logic             last_sample;

  modport source (output valid, output dac_code, output last_sample, input ready);
  modport sink (input valid, input dac_code, input last_sample, output ready);
endinterface

### hw/rtl/dsg_cfg_if.sv
// Register write channel.
interface dsg_cfg_if import dsg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/dsg_datapath.sv
// Phase accumulator, sine table, scaling and output register.
module dsg_datapath import dsg_pkg::*; #(
  parameter int TABLE_INDEX_BITS = 8,
  parameter int PHASE_WIDTH      = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  dsg_cmd_t               cmd,
  output logic [DAC_W-1:0]       dac_code,
  output logic                   last_sample
);

  localparam int ROM_DEPTH = 1 << TABLE_INDEX_BITS;

  logic [STEP_W-1:0]            phase_step;
  logic [LEVEL_W-1:0]           offset_level;
  logic [LEVEL_W-1:0]           amp_level;
  logic [PHASE_WIDTH-1:0]       acc;
  logic [PHASE_WIDTH+STEP_W-1:0] step_ext;
  logic [PHASE_WIDTH-1:0]       step_pw;

  logic signed [SINE_W-1:0]     sine_rom [ROM_DEPTH];
  logic [TABLE_INDEX_BITS-1:0]  rom_idx;
  logic signed [SINE_W-1:0]     sine;

  logic signed [NUM_W-1:0]      num;
  logic signed [NUM_W-1:0]      num_next;
  logic [MAG_W-1:0]             mag;
  logic [PROD_W-1:0]            prodk;
  logic [WIDE_W-1:0]            numx;
  logic                         pos;
  logic [Q_W-1:0]               q_est;
  logic [WIDE_W-1:0]            qd;
  logic [WIDE_W-1:0]            numx_q;
  logic                         pos_q;
  logic [WIDE_W-1:0]            diff;
  logic [Q_W-1:0]               q_fin;
  logic [DAC_W-1:0]             code_next;

  // Step reduced modulo 2^PHASE_WIDTH
  assign step_ext = {{PHASE_WIDTH{1'b0}}, phase_step};
  assign step_pw  = step_ext[PHASE_WIDTH-1:0];

  // Registers and phase accumulator; a step write restarts the phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= '0;
      offset_level <= OFFSET_RESET;
      amp_level    <= AMPLITUDE_RESET;
      acc          <= '0;
    end else if (cfg_we) begin
      unique case (dsg_reg_t'(cfg_index))
        REG_PHASE_STEP: begin
          phase_step <= cfg_data;
          acc        <= '0;
        end
        REG_OFFSET:     offset_level <= cfg_data[LEVEL_W-1:0];
        REG_AMPLITUDE:  amp_level    <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end else if (cmd.acc_step) begin
      acc <= acc + step_pw;
    end
  end

  // Constant sine table, built at elaboration
  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
    localparam logic [SINE_W-1:0] Entry = sine_entry(64'(k), TABLE_INDEX_BITS);
    assign sine_rom[k] = Entry;
  end

  assign rom_idx = acc[PHASE_WIDTH-1 -: TABLE_INDEX_BITS];

  always_ff @(posedge clk) begin
    if (cmd.rom_load) begin
      sine <= sine_rom[rom_idx];
    end
  end

  // Numerator: offset*2^15 + sine*amplitude
  assign num_next = $signed(NUM_W'({offset_level, 15'd0}))
                  + NUM_W'(sine) * $signed(NUM_W'(amp_level));

  always_ff @(posedge clk) begin
    if (cmd.mac_load) begin
      num <= num_next;
    end
  end

  // Reciprocal estimate and exact numerator times 4095
  assign mag = num[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mulk_load) begin
      prodk <= PROD_W'(mag) * PROD_W'(RECIP_K);
      numx  <= (WIDE_W'(mag) << 12) - WIDE_W'(mag);
      pos   <= (num > 0);
    end
  end

  // Quotient estimate and its product with the divisor
  always_ff @(posedge clk) begin
    if (cmd.qest_load) begin
      q_est  <= prodk[PROD_W-1 -: Q_W];
      qd     <= WIDE_W'(prodk[PROD_W-1 -: Q_W]) * FULL_SCALE;
      numx_q <= numx;
      pos_q  <= pos;
    end
  end

  // One-step correction, then clamp to the converter range
  assign diff  = numx_q - qd;
  assign q_fin = q_est + Q_W'(diff >= FULL_SCALE);

  always_comb begin
    priority if (!pos_q) begin
      code_next = '0;
    end else if (q_fin > Q_W'(CODE_MAX)) begin
      code_next = CODE_MAX;
    end else begin
      code_next = q_fin[DAC_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dac_code    <= code_next;
      last_sample <= cmd.last;
    end
  end

endmodule

### hw/rtl/dsg_ctrl.sv
// Sequencer: walks each sample of a burst through the datapath steps.
`include "dds_sine_generator_assert.svh"

module dsg_ctrl import dsg_pkg::*; #(
  parameter int SAMPLES_PER_REFILL = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     refill_valid,
  input  logic     refill_request,
  output logic     refill_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output dsg_cmd_t cmd
);

  localparam int CNT_W = (SAMPLES_PER_REFILL > 1) ? $clog2(SAMPLES_PER_REFILL) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_REFILL - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PHASE = 7'b0000010,
    S_ROM   = 7'b0000100,
    S_MAC   = 7'b0001000,
    S_MULK  = 7'b0010000,
    S_QEST  = 7'b0100000,
    S_CORR  = 7'b1000000
  } dsg_state_t;

  dsg_state_t       state;
  dsg_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             refill_accept;
  logic             out_free;
  logic             is_last;

  assign refill_ready  = (state == S_IDLE);
  assign refill_accept = refill_valid && refill_ready;
  assign out_free      = !out_valid || out_ready;
  assign is_last       = (cnt == CNT_LAST);

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.last   = is_last;
    unique case (state)
      S_IDLE: begin
        if (refill_accept && refill_request) begin
          state_next = S_PHASE;
          cnt_next   = '0;
        end
      end
      S_PHASE: begin
        cmd.acc_step = 1'b1;
        state_next   = S_ROM;
      end
      S_ROM: begin
        cmd.rom_load = 1'b1;
        state_next   = S_MAC;
      end
      S_MAC: begin
        cmd.mac_load = 1'b1;
        state_next   = S_MULK;
      end
      S_MULK: begin
        cmd.mulk_load = 1'b1;
        state_next    = S_QEST;
      end
      S_QEST: begin
        cmd.qest_load = 1'b1;
        state_next    = S_CORR;
      end
      S_CORR: begin
        // wait here while the output register still holds an untaken beat
        if (out_free) begin
          cmd.out_load = 1'b1;
          if (is_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_PHASE;
            cnt_next   = cnt + CNT_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `DSG_ASSERT_NEXT(a_burst_start, refill_accept && refill_request, state == S_PHASE, "refill did not start a burst")
  `DSG_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "output beat overwritten")
  `DSG_ASSERT_NEXT(a_burst_end, cmd.out_load && cmd.last, state == S_IDLE && out_valid, "burst end lost")
  `DSG_ASSERT_NEXT(a_idle_hold, refill_accept && !refill_request, state == S_IDLE, "empty event started work")

endmodule

### hw/rtl/dds_sine_generator.sv
// DDS sine source for a 12-bit converter: top level.
//
// Channels: refill (sink) carries refill_request; sample (source) carries dac_code
// and last_sample; cfg (sink) writes phase_step (0), offset level (1), amplitude (2).
// cfg is always ready; write it only while the block is idle. A phase_step write
// also clears the phase accumulator.
// A refill beat with refill_request set yields SAMPLES_PER_REFILL sample beats,
// the last one flagged by last_sample; a beat with it clear is taken and yields
// nothing. Each sample walks six sequencer steps (phase add, table read,
// multiply-add, reciprocal multiply, quotient product, correction and clamp), and
// the block takes no new refill beat while a burst is in progress.
// The output register holds a sample until the receiver takes it; the sequencer
// keeps computing and stalls only at the correction step if that register is still
// full. A refill beat is taken once the last sample of the burst sits in it.
// Reset (rst, synchronous) loads phase_step 0, offset 1250 mV, amplitude 1000 mV,
// clears the accumulator and drops any pending sample.
module dds_sine_generator import dsg_pkg::*; #(
  parameter int TABLE_INDEX_BITS   = 8,
  parameter int PHASE_WIDTH        = 32,
  parameter int SAMPLES_PER_REFILL = 2
) (
  input logic          clk,
  input logic          rst,
  dsg_refill_if.sink   refill,
  dsg_sample_if.source sample,
  dsg_cfg_if.sink      cfg
);

  dsg_cmd_t cmd;

  assign cfg.ready = 1'b1;

  dsg_ctrl #(
    .SAMPLES_PER_REFILL (SAMPLES_PER_REFILL)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .refill_valid   (refill.valid),
    .refill_request (refill.refill_request),
    .refill_ready   (refill.ready),
    .out_ready      (sample.ready),
    .out_valid      (sample.valid),
    .cmd            (cmd)
  );

  dsg_datapath #(
    .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
    .PHASE_WIDTH      (PHASE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .cmd         (cmd),
    .dac_code    (sample.dac_code),
    .last_sample (sample.last_sample)
  );

endmodule
